[sv/wdtd_pkg.sv]
`timescale 1ns / 1ps

package wdtd_pkg;

   localparam int MAX_SAMPLES = 64;
   localparam int MAX_SITES = 1024;
   localparam int SITE_CAP_INT = (MAX_SITES < 2047) ? MAX_SITES : 2047;

   localparam logic [10:0] SITE_CAP = 11'(SITE_CAP_INT);
   localparam logic [6:0] N_MIN = 7'd2;
   localparam logic [6:0] N_MAX = 7'(MAX_SAMPLES);
   localparam logic [40:0] Q_CAP = 41'h100_0000_0000;

   localparam int MUL_A_WIDTH = 48;
   localparam int MUL_B_WIDTH = 24;

   typedef enum logic [2:0] {
      CSR_SAMPLE_COUNT = 3'd0,
      CSR_WINDOW_LOW = 3'd1,
      CSR_WINDOW_HIGH = 3'd2,
      CSR_HARMONIC_SUM = 3'd3,
      CSR_HARMONIC_SQUARE_SUM = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic [MUL_A_WIDTH-1:0] op_a;
      logic [MUL_B_WIDTH-1:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic done;
      logic [63:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic start;
      logic [5:0] shift;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [63:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic start;
      logic [63:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic done;
      logic [31:0] root;
   } sqrt_rsp_type;

endpackage

[sv/window_diversity_tajima_d.sv]
`timescale 1ns / 1ps

// A site transaction that is not marked last goes through accept, popcount, pair
// product and accumulation. A last transaction then runs the window statistics
// on three shared sequential units, a 24-step shift-add multiplier, a restoring
// divider that retires one quotient bit per cycle and a 32-step square root. The
// full sequence uses up to eleven divisions, eleven multiplications and two square
// roots, and is shortened when no site was counted or the harmonic sum is zero. The
// result sits in an output register, so the next site is accepted while it waits.

module window_diversity_tajima_d
   import wdtd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_site_position,
   input  logic [63:0]        req_allele_bits,
   input  logic               req_last_site,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_diversity_sum,
   output logic [31:0]        rsp_diversity_spread,
   output logic [31:0]        rsp_watterson_theta,
   output logic signed [31:0] rsp_tajima_d,
   output logic [10:0]        rsp_site_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data
);

   typedef enum logic [28:0] {
      S_IDLE = 29'd1 << 0,
      S_POP  = 29'd1 << 1,
      S_PROD = 29'd1 << 2,
      S_ACC  = 29'd1 << 3,
      S_MC   = 29'd1 << 4,
      S_PI   = 29'd1 << 5,
      S_MS2  = 29'd1 << 6,
      S_S1S  = 29'd1 << 7,
      S_MMC  = 29'd1 << 8,
      S_MCC  = 29'd1 << 9,
      S_DX   = 29'd1 << 10,
      S_SPR  = 29'd1 << 11,
      S_TH   = 29'd1 << 12,
      S_B1   = 29'd1 << 13,
      S_NN   = 29'd1 << 14,
      S_B2   = 29'd1 << 15,
      S_T1   = 29'd1 << 16,
      S_AN   = 29'd1 << 17,
      S_T2   = 29'd1 << 18,
      S_AA   = 29'd1 << 19,
      S_T3   = 29'd1 << 20,
      S_E1   = 29'd1 << 21,
      S_E2   = 29'd1 << 22,
      S_E1M  = 29'd1 << 23,
      S_MM1  = 29'd1 << 24,
      S_E2M  = 29'd1 << 25,
      S_SD   = 29'd1 << 26,
      S_FIN  = 29'd1 << 27,
      S_OUT  = 29'd1 << 28
   } state_type;

   function automatic logic [31:0] sat32(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic logic [40:0] capq(input logic [63:0] v);
      return (v > 64'(Q_CAP)) ? Q_CAP : v[40:0];
   endfunction

   function automatic logic signed [63:0] signed_cap(input logic neg, input logic [63:0] v);
      logic signed [63:0] mag;
      mag = $signed({23'd0, capq(v)});
      return neg ? -mag : mag;
   endfunction

   state_type state_ff, state_in;
   logic launch_ff, launch_in;

   logic [6:0] sample_count_ff, sample_count_in;
   logic [15:0] window_low_ff, window_low_in;
   logic [15:0] window_high_ff, window_high_in;
   logic [23:0] harm_ff, harm_in;
   logic [23:0] harm_sq_ff, harm_sq_in;

   logic [10:0] cnt_ff, cnt_in;
   logic [20:0] s1_ff, s1_in;
   logic [30:0] s2_ff, s2_in;

   logic in_win_ff, in_win_in;
   logic last_ff, last_in;
   logic [63:0] bits_ff, bits_in;
   logic [6:0] k_ff, k_in;
   logic [10:0] d_ff, d_in;

   logic [10:0] c_ff, c_in;
   logic [31:0] pi_ff, pi_in;
   logic [41:0] x_ff, x_in;
   logic [31:0] spread_ff, spread_in;
   logic [31:0] th_ff, th_in;
   logic signed [63:0] c1_ff, c1_in;
   logic signed [63:0] c2_ff, c2_in;
   logic signed [63:0] e1_ff, e1_in;
   logic signed [63:0] e2_ff, e2_in;
   logic signed [63:0] var_ff, var_in;
   logic [31:0] sd_ff, sd_in;
   logic signed [31:0] dval_ff, dval_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] out_pi_ff, out_pi_in;
   logic [31:0] out_spread_ff, out_spread_in;
   logic [31:0] out_th_ff, out_th_in;
   logic signed [31:0] out_d_ff, out_d_in;
   logic [10:0] out_cnt_ff, out_cnt_in;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   logic [6:0] n_eff;
   logic [63:0] sample_mask;
   logic [6:0] pop;
   logic [10:0] cnt_new;
   logic [21:0] d_sq;
   logic signed [32:0] num;
   logic [63:0] num_mag;
   logic [63:0] c1_mag;
   logic [63:0] c2_mag;
   logic [63:0] e1_mag;
   logic [63:0] e2_mag;
   logic signed [63:0] prod_signed;
   logic [63:0] q_fin;

   wdtd_mul u_mul (
      .clock(clock),
      .reset(reset),
      .req(mul_req),
      .rsp(mul_rsp)
   );

   wdtd_div u_div (
      .clock(clock),
      .reset(reset),
      .req(div_req),
      .rsp(div_rsp)
   );

   wdtd_sqrt u_sqrt (
      .clock(clock),
      .reset(reset),
      .req(sqrt_req),
      .rsp(sqrt_rsp)
   );

   always_comb begin
      if (sample_count_ff < N_MIN) begin
         n_eff = N_MIN;
      end else if (sample_count_ff > N_MAX) begin
         n_eff = N_MAX;
      end else begin
         n_eff = sample_count_ff;
      end
      sample_mask = (n_eff >= 7'd64) ? '1 : ((64'd1 << n_eff) - 64'd1);
      pop = '0;
      for (int i = 0; i < 64; i++) begin
         pop = pop + 7'(bits_ff[i]);
      end
      d_sq = d_ff * d_ff;
      cnt_new = in_win_ff ? (cnt_ff + 11'd1) : cnt_ff;
      num = $signed({1'b0, pi_ff}) - $signed({1'b0, th_ff});
      num_mag = (num < 0) ? 64'(-num) : 64'(num);
      c1_mag = (c1_ff < 0) ? 64'(-c1_ff) : 64'(c1_ff);
      c2_mag = (c2_ff < 0) ? 64'(-c2_ff) : 64'(c2_ff);
      e1_mag = (e1_ff < 0) ? 64'(-e1_ff) : 64'(e1_ff);
      e2_mag = (e2_ff < 0) ? 64'(-e2_ff) : 64'(e2_ff);
      prod_signed = $signed(mul_rsp.product);
      q_fin = div_rsp.quotient;
   end

   always_comb begin
      mul_req = '0;
      div_req = '0;
      sqrt_req = '0;
      unique case (state_ff)
         S_MC: begin
            mul_req.op_a = 48'(n_eff);
            mul_req.op_b = 24'(n_eff - 7'd1);
         end
         S_PI: begin
            div_req.shift = 6'd16;
            div_req.dividend = 64'(s1_ff);
            div_req.divisor = 64'(c_ff);
         end
         S_MS2: begin
            mul_req.op_a = 48'(s2_ff);
            mul_req.op_b = 24'(cnt_ff);
         end
         S_S1S: begin
            mul_req.op_a = 48'(s1_ff);
            mul_req.op_b = 24'(s1_ff);
         end
         S_MMC: begin
            mul_req.op_a = 48'(c_ff);
            mul_req.op_b = 24'(cnt_ff);
         end
         S_MCC: begin
            mul_req.op_a = 48'(mul_rsp.product[21:0]);
            mul_req.op_b = 24'(c_ff);
         end
         S_DX: begin
            div_req.shift = 6'd32;
            div_req.dividend = 64'(x_ff);
            div_req.divisor = 64'(mul_rsp.product[32:0]);
         end
         S_SPR: begin
            sqrt_req.radicand = div_rsp.quotient;
         end
         S_TH: begin
            div_req.shift = 6'd36;
            div_req.dividend = 64'(cnt_ff);
            div_req.divisor = 64'(harm_ff);
         end
         S_B1: begin
            div_req.shift = 6'd32;
            div_req.dividend = 64'(n_eff) + 64'd1;
            div_req.divisor = 64'(n_eff - 7'd1) * 64'd3;
         end
         S_NN: begin
            mul_req.op_a = 48'(n_eff);
            mul_req.op_b = 24'(n_eff);
         end
         S_B2: begin
            div_req.shift = 6'd32;
            div_req.dividend = (64'(mul_rsp.product[12:0]) + 64'(n_eff) + 64'd3) << 1;
            div_req.divisor = 64'(c_ff) * 64'd18;
         end
         S_T1: begin
            div_req.shift = 6'd52;
            div_req.dividend = 64'd1;
            div_req.divisor = 64'(harm_ff);
         end
         S_AN: begin
            mul_req.op_a = 48'(harm_ff);
            mul_req.op_b = 24'(n_eff);
         end
         S_T2: begin
            div_req.shift = 6'd52;
            div_req.dividend = 64'(n_eff) + 64'd2;
            div_req.divisor = 64'(mul_rsp.product[30:0]);
         end
         S_AA: begin
            mul_req.op_a = 48'(harm_ff);
            mul_req.op_b = harm_ff;
         end
         S_T3: begin
            div_req.shift = 6'd52;
            div_req.dividend = 64'(harm_sq_ff);
            div_req.divisor = 64'(mul_rsp.product[47:0]);
         end
         S_E1: begin
            div_req.shift = 6'd20;
            div_req.dividend = c1_mag;
            div_req.divisor = 64'(harm_ff);
         end
         S_E2: begin
            div_req.shift = 6'd40;
            div_req.dividend = c2_mag;
            div_req.divisor = 64'(mul_rsp.product[47:0]) + (64'(harm_sq_ff) << 20);
         end
         S_E1M: begin
            mul_req.op_a = e1_mag[47:0];
            mul_req.op_b = 24'(cnt_ff);
         end
         S_MM1: begin
            mul_req.op_a = 48'(cnt_ff);
            mul_req.op_b = 24'(cnt_ff - 11'd1);
         end
         S_E2M: begin
            mul_req.op_a = e2_mag[47:0];
            mul_req.op_b = mul_rsp.product[23:0];
         end
         S_SD: begin
            sqrt_req.radicand = 64'(var_ff);
         end
         S_FIN: begin
            div_req.shift = 6'd16;
            div_req.dividend = num_mag;
            div_req.divisor = 64'(sd_ff);
         end
         default: begin
         end
      endcase
      mul_req.start = launch_ff && (state_ff inside {S_MC, S_MS2, S_S1S, S_MMC, S_MCC,
         S_NN, S_AN, S_AA, S_E1M, S_MM1, S_E2M});
      div_req.start = launch_ff && (state_ff inside {S_PI, S_DX, S_TH, S_B1, S_B2, S_T1,
         S_T2, S_T3, S_E1, S_E2, S_FIN});
      sqrt_req.start = launch_ff && (state_ff inside {S_SPR, S_SD});
   end

   always_comb begin
      state_in = state_ff;
      launch_in = 1'b0;
      sample_count_in = sample_count_ff;
      window_low_in = window_low_ff;
      window_high_in = window_high_ff;
      harm_in = harm_ff;
      harm_sq_in = harm_sq_ff;
      cnt_in = cnt_ff;
      s1_in = s1_ff;
      s2_in = s2_ff;
      in_win_in = in_win_ff;
      last_in = last_ff;
      bits_in = bits_ff;
      k_in = k_ff;
      d_in = d_ff;
      c_in = c_ff;
      pi_in = pi_ff;
      x_in = x_ff;
      spread_in = spread_ff;
      th_in = th_ff;
      c1_in = c1_ff;
      c2_in = c2_ff;
      e1_in = e1_ff;
      e2_in = e2_ff;
      var_in = var_ff;
      sd_in = sd_ff;
      dval_in = dval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_pi_in = out_pi_ff;
      out_spread_in = out_spread_ff;
      out_th_in = out_th_ff;
      out_d_in = out_d_ff;
      out_cnt_in = out_cnt_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SAMPLE_COUNT: sample_count_in = csr_data[6:0];
            CSR_WINDOW_LOW: window_low_in = csr_data[15:0];
            CSR_WINDOW_HIGH: window_high_in = csr_data[15:0];
            CSR_HARMONIC_SUM: harm_in = csr_data;
            CSR_HARMONIC_SQUARE_SUM: harm_sq_in = csr_data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               in_win_in = (req_site_position > window_low_ff) &&
                  (req_site_position <= window_high_ff) && (cnt_ff < SITE_CAP);
               last_in = req_last_site;
               bits_in = req_allele_bits & sample_mask;
               state_in = S_POP;
            end
         end
         S_POP: begin
            k_in = pop;
            state_in = S_PROD;
         end
         S_PROD: begin
            d_in = 11'(k_ff * (n_eff - k_ff));
            state_in = S_ACC;
         end
         S_ACC: begin
            if (in_win_ff) begin
               cnt_in = cnt_new;
               s1_in = s1_ff + 21'(d_ff);
               s2_in = s2_ff + 31'(d_sq);
            end
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (cnt_new == 11'd0) begin
               state_in = S_OUT;
            end else begin
               state_in = S_MC;
               launch_in = 1'b1;
            end
         end
         S_MC: begin
            if (mul_rsp.done) begin
               c_in = mul_rsp.product[11:1];
               state_in = S_PI;
               launch_in = 1'b1;
            end
         end
         S_PI: begin
            if (div_rsp.done) begin
               pi_in = sat32(div_rsp.quotient);
               state_in = S_MS2;
               launch_in = 1'b1;
            end
         end
         S_MS2: begin
            if (mul_rsp.done) begin
               x_in = mul_rsp.product[41:0];
               state_in = S_S1S;
               launch_in = 1'b1;
            end
         end
         S_S1S: begin
            if (mul_rsp.done) begin
               x_in = (x_ff > mul_rsp.product[41:0]) ? (x_ff - mul_rsp.product[41:0]) : '0;
               state_in = S_MMC;
               launch_in = 1'b1;
            end
         end
         S_MMC: begin
            if (mul_rsp.done) begin
               state_in = S_MCC;
               launch_in = 1'b1;
            end
         end
         S_MCC: begin
            if (mul_rsp.done) begin
               state_in = S_DX;
               launch_in = 1'b1;
            end
         end
         S_DX: begin
            if (div_rsp.done) begin
               state_in = S_SPR;
               launch_in = 1'b1;
            end
         end
         S_SPR: begin
            if (sqrt_rsp.done) begin
               spread_in = sqrt_rsp.root;
               if (harm_ff == 24'd0) begin
                  th_in = 32'hFFFF_FFFF;
                  sd_in = '0;
                  state_in = S_FIN;
               end else begin
                  state_in = S_TH;
                  launch_in = 1'b1;
               end
            end
         end
         S_TH: begin
            if (div_rsp.done) begin
               th_in = sat32(div_rsp.quotient);
               state_in = S_B1;
               launch_in = 1'b1;
            end
         end
         S_B1: begin
            if (div_rsp.done) begin
               c1_in = signed_cap(1'b0, div_rsp.quotient);
               state_in = S_NN;
               launch_in = 1'b1;
            end
         end
         S_NN: begin
            if (mul_rsp.done) begin
               state_in = S_B2;
               launch_in = 1'b1;
            end
         end
         S_B2: begin
            if (div_rsp.done) begin
               c2_in = signed_cap(1'b0, div_rsp.quotient);
               state_in = S_T1;
               launch_in = 1'b1;
            end
         end
         S_T1: begin
            if (div_rsp.done) begin
               c1_in = c1_ff - signed_cap(1'b0, div_rsp.quotient);
               state_in = S_AN;
               launch_in = 1'b1;
            end
         end
         S_AN: begin
            if (mul_rsp.done) begin
               state_in = S_T2;
               launch_in = 1'b1;
            end
         end
         S_T2: begin
            if (div_rsp.done) begin
               c2_in = c2_ff - signed_cap(1'b0, div_rsp.quotient);
               state_in = S_AA;
               launch_in = 1'b1;
            end
         end
         S_AA: begin
            if (mul_rsp.done) begin
               state_in = S_T3;
               launch_in = 1'b1;
            end
         end
         S_T3: begin
            if (div_rsp.done) begin
               c2_in = c2_ff + signed_cap(1'b0, div_rsp.quotient);
               state_in = S_E1;
               launch_in = 1'b1;
            end
         end
         S_E1: begin
            if (div_rsp.done) begin
               e1_in = signed_cap(c1_ff < 0, div_rsp.quotient);
               state_in = S_E2;
               launch_in = 1'b1;
            end
         end
         S_E2: begin
            if (div_rsp.done) begin
               e2_in = signed_cap(c2_ff < 0, div_rsp.quotient);
               state_in = S_E1M;
               launch_in = 1'b1;
            end
         end
         S_E1M: begin
            if (mul_rsp.done) begin
               var_in = (e1_ff < 0) ? -prod_signed : prod_signed;
               state_in = S_MM1;
               launch_in = 1'b1;
            end
         end
         S_MM1: begin
            if (mul_rsp.done) begin
               state_in = S_E2M;
               launch_in = 1'b1;
            end
         end
         S_E2M: begin
            if (mul_rsp.done) begin
               var_in = var_ff + ((e2_ff < 0) ? -prod_signed : prod_signed);
               if (var_in > 0) begin
                  state_in = S_SD;
                  launch_in = 1'b1;
               end else begin
                  sd_in = '0;
                  state_in = S_FIN;
               end
            end
         end
         S_SD: begin
            if (sqrt_rsp.done) begin
               sd_in = sqrt_rsp.root;
               state_in = S_FIN;
               launch_in = (sqrt_rsp.root != 32'd0);
            end
         end
         S_FIN: begin
            if (sd_ff == 32'd0) begin
               if (num > 0) begin
                  dval_in = 32'sh7FFF_FFFF;
               end else if (num < 0) begin
                  dval_in = 32'sh8000_0000;
               end else begin
                  dval_in = '0;
               end
               state_in = S_OUT;
            end else if (div_rsp.done) begin
               if (num < 0) begin
                  dval_in = (q_fin >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(q_fin[31:0]);
               end else begin
                  dval_in = (q_fin >= 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q_fin[31:0]);
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (cnt_ff == 11'd0) begin
                  out_pi_in = '0;
                  out_spread_in = '0;
                  out_th_in = '0;
                  out_d_in = '0;
               end else begin
                  out_pi_in = pi_ff;
                  out_spread_in = spread_ff;
                  out_th_in = th_ff;
                  out_d_in = dval_ff;
               end
               out_cnt_in = cnt_ff;
               cnt_in = '0;
               s1_in = '0;
               s2_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         launch_ff <= 1'b0;
         sample_count_ff <= 7'd64;
         window_low_ff <= 16'd0;
         window_high_ff <= 16'd65535;
         harm_ff <= '0;
         harm_sq_ff <= '0;
         cnt_ff <= '0;
         s1_ff <= '0;
         s2_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         launch_ff <= launch_in;
         sample_count_ff <= sample_count_in;
         window_low_ff <= window_low_in;
         window_high_ff <= window_high_in;
         harm_ff <= harm_in;
         harm_sq_ff <= harm_sq_in;
         cnt_ff <= cnt_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_win_ff <= in_win_in;
      last_ff <= last_in;
      bits_ff <= bits_in;
      k_ff <= k_in;
      d_ff <= d_in;
      c_ff <= c_in;
      pi_ff <= pi_in;
      x_ff <= x_in;
      spread_ff <= spread_in;
      th_ff <= th_in;
      c1_ff <= c1_in;
      c2_ff <= c2_in;
      e1_ff <= e1_in;
      e2_ff <= e2_in;
      var_ff <= var_in;
      sd_ff <= sd_in;
      dval_ff <= dval_in;
      out_pi_ff <= out_pi_in;
      out_spread_ff <= out_spread_in;
      out_th_ff <= out_th_in;
      out_d_ff <= out_d_in;
      out_cnt_ff <= out_cnt_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_diversity_sum = out_pi_ff;
   assign rsp_diversity_spread = out_spread_ff;
   assign rsp_watterson_theta = out_th_ff;
   assign rsp_tajima_d = out_d_ff;
   assign rsp_site_count = out_cnt_ff;

   // Once a transaction is taken, no further site is taken until its work is done.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a site is still in progress");

   // The shared units are never started together.
   assert property (@(posedge clock) disable iff (reset)
      !(mul_req.start && div_req.start) && !(div_req.start && sqrt_req.start) &&
      !(mul_req.start && sqrt_req.start))
      else $error("two arithmetic units started in the same cycle");

   // The site counter never passes its cap.
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= SITE_CAP)
      else $error("site count exceeded its cap");

endmodule

[sv/wdtd_mul.sv]
`timescale 1ns / 1ps

module wdtd_mul
   import wdtd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] a_ff, a_in;
   logic [MUL_B_WIDTH-1:0] b_ff, b_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         acc_in = '0;
         a_in = 64'(req.op_a);
         b_in = req.op_b;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in = a_ff << 1;
         b_in = b_ff >> 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(MUL_B_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign rsp.done = done_ff;
   assign rsp.product = acc_ff;

endmodule

[sv/wdtd_div.sv]
`timescale 1ns / 1ps

module wdtd_div
   import wdtd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic ovf_ff, ovf_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [6:0] last_ff, last_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] trial;
   logic ge;

   always_comb begin
      trial = {rem_ff[62:0], num_ff[63]};
      ge = (trial >= den_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      ovf_in = ovf_ff;
      cnt_in = cnt_ff;
      last_in = last_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         ovf_in = 1'b0;
         cnt_in = '0;
         last_in = 7'd63 + 7'(req.shift);
         num_in = req.dividend;
         den_in = req.divisor;
         rem_in = '0;
         quo_in = '0;
      end else if (busy_ff) begin
         ovf_in = ovf_ff | quo_ff[63];
         rem_in = ge ? (trial - den_ff) : trial;
         quo_in = {quo_ff[62:0], ge};
         num_in = num_ff << 1;
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == last_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      last_ff <= last_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = ovf_ff ? '1 : quo_ff;

endmodule

[sv/wdtd_sqrt.sv]
`timescale 1ns / 1ps

module wdtd_sqrt
   import wdtd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sqrt_req_type req,
   output sqrt_rsp_type rsp
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [63:0] val_ff, val_in;
   logic [63:0] root_ff, root_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] trial;

   always_comb begin
      trial = root_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      val_in = val_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         val_in = req.radicand;
         root_in = '0;
         bit_in = 64'd1 << 62;
      end else if (busy_ff) begin
         if (val_ff >= trial) begin
            val_in = val_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      val_ff <= val_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff[31:0];

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import wdtd_pkg::*;

   localparam logic [2:0] CSR_SPARE_A = 3'd5;
   localparam logic [2:0] CSR_SPARE_B = 3'd6;
   localparam logic [2:0] CSR_SPARE_C = 3'd7;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD_CYCLES = 5000;

   typedef enum logic {ROW_SITE, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [31:0]        diversity_sum;
      logic [31:0]        diversity_spread;
      logic [31:0]        watterson_theta;
      logic signed [31:0] tajima_d;
      logic [10:0]        site_count;
   } window_stats_type;

   typedef struct {
      row_kind_type     kind;
      logic [2:0]       csr_idx;
      logic [23:0]      csr_value;
      logic [15:0]      position;
      logic [63:0]      alleles;
      logic             last;
      bit               typed;
      window_stats_type stats;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [15:0]        req_site_position;
   logic [63:0]        req_allele_bits;
   logic               req_last_site;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [31:0]        rsp_diversity_sum;
   logic [31:0]        rsp_diversity_spread;
   logic [31:0]        rsp_watterson_theta;
   logic signed [31:0] rsp_tajima_d;
   logic [10:0]        rsp_site_count;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [23:0]        csr_data;

   window_diversity_tajima_d u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_site_position(req_site_position), .req_allele_bits(req_allele_bits),
      .req_last_site(req_last_site),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_diversity_sum(rsp_diversity_sum), .rsp_diversity_spread(rsp_diversity_spread),
      .rsp_watterson_theta(rsp_watterson_theta), .rsp_tajima_d(rsp_tajima_d),
      .rsp_site_count(rsp_site_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Shadow copy of the block's registers and running sums.
   longint unsigned cfg_samples, cfg_low, cfg_high, cfg_a1, cfg_a2;
   longint unsigned sum_sites, sum_pairs, sum_pair_squares;

   window_stats_type pending_stats[$];
   stim_row_type     stim_rows[$];
   int unsigned      mismatch_count;
   int unsigned      burst_left;
   int unsigned      hold_requests;
   int unsigned      hold_served;
   int unsigned      hold_left;
   int unsigned      ready_mode;
   int unsigned      ready_mode_left;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   initial begin
      #30ms;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic longint unsigned shifted_quotient(longint unsigned x, int sh,
                                                        longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      longint unsigned next_bit;
      q = 0;
      r = 0;
      if (d == 0) begin
         return '1;
      end
      for (int i = 0; i < 64 + sh; i++) begin
         next_bit = (i < 64) ? ((x >> (63 - i)) & 64'd1) : 64'd0;
         if (q[63]) begin
            return '1;
         end
         r = (r << 1) | next_bit;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic longint unsigned cap40(longint unsigned v);
      return (v > (64'd1 << 40)) ? (64'd1 << 40) : v;
   endfunction

   function automatic longint signed_quotient(longint v, int sh, longint unsigned d);
      longint unsigned mag;
      longint q;
      mag = (v < 0) ? -v : v;
      q = longint'(cap40(shifted_quotient(mag, sh, d)));
      return (v < 0) ? -q : q;
   endfunction

   function automatic longint unsigned sat_u32(longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
   endfunction

   function automatic longint unsigned clamped_samples();
      if (cfg_samples < 2) return 2;
      if (cfg_samples > MAX_SAMPLES) return MAX_SAMPLES;
      return cfg_samples;
   endfunction

   function automatic void apply_csr(logic [2:0] idx, logic [23:0] value);
      case (idx)
         CSR_SAMPLE_COUNT: cfg_samples = value[6:0];
         CSR_WINDOW_LOW: cfg_low = value[15:0];
         CSR_WINDOW_HIGH: cfg_high = value[15:0];
         CSR_HARMONIC_SUM: cfg_a1 = value;
         CSR_HARMONIC_SQUARE_SUM: cfg_a2 = value;
         default: ;
      endcase
   endfunction

   // Folds one site into the window sums and, on the last site, computes the window
   // statistics. Returns 1 when a result is due.
   function automatic bit predict_window(logic [15:0] position, logic [63:0] alleles,
                                         logic last, output window_stats_type stats);
      longint unsigned n, k, d, masked, m, s1, s2, pairs, pi_q, theta_q, spread_x, sd;
      longint b1, b2, c1, c2, e1, e2, variance, num, mag, q;
      int dval;
      n = clamped_samples();
      stats = '0;
      if (position > cfg_low && position <= cfg_high && sum_sites < SITE_CAP_INT) begin
         masked = (n >= 64) ? alleles : (alleles & ((64'd1 << n) - 1));
         k = $countones(masked);
         d = k * (n - k);
         sum_sites++;
         sum_pairs += d;
         sum_pair_squares += d * d;
      end
      if (!last) begin
         return 1'b0;
      end
      m = sum_sites;
      s1 = sum_pairs;
      s2 = sum_pair_squares;
      sum_sites = 0;
      sum_pairs = 0;
      sum_pair_squares = 0;
      if (m == 0) begin
         return 1'b1;
      end
      pairs = n * (n - 1) / 2;
      pi_q = sat_u32(shifted_quotient(s1, 16, pairs));
      spread_x = (m * s2 > s1 * s1) ? m * s2 - s1 * s1 : 0;
      stats.diversity_spread =
         sat_u32(int_sqrt(shifted_quotient(spread_x, 32, m * pairs * pairs)));
      theta_q = (cfg_a1 == 0) ? 64'hFFFF_FFFF : sat_u32(shifted_quotient(m, 36, cfg_a1));
      sd = 0;
      if (cfg_a1 != 0) begin
         b1 = longint'(cap40(shifted_quotient(n + 1, 32, 3 * (n - 1))));
         b2 = longint'(cap40(shifted_quotient(2 * (n * n + n + 3), 32, 9 * n * (n - 1))));
         c1 = b1 - longint'(cap40(shifted_quotient(1, 52, cfg_a1)));
         c2 = b2 - longint'(cap40(shifted_quotient(n + 2, 52, cfg_a1 * n)))
            + longint'(cap40(shifted_quotient(cfg_a2, 52, cfg_a1 * cfg_a1)));
         e1 = signed_quotient(c1, 20, cfg_a1);
         e2 = signed_quotient(c2, 40, cfg_a1 * cfg_a1 + (cfg_a2 << 20));
         variance = e1 * longint'(m) + e2 * longint'(m * (m - 1));
         if (variance > 0) sd = int_sqrt(longint'(variance));
      end
      num = longint'(pi_q) - longint'(theta_q);
      if (sd == 0) begin
         dval = (num > 0) ? 32'h7FFF_FFFF : ((num < 0) ? 32'h8000_0000 : 0);
      end else begin
         mag = (num < 0) ? -num : num;
         q = longint'(shifted_quotient(mag, 16, sd));
         if (num < 0) begin
            dval = (longint'(unsigned'(q)) >= 64'h8000_0000 || q < 0) ?
               32'h8000_0000 : int'(-q);
         end else begin
            dval = (q >= 64'h7FFF_FFFF || q < 0) ? 32'h7FFF_FFFF : int'(q);
         end
      end
      stats.diversity_sum = pi_q;
      stats.watterson_theta = theta_q;
      stats.tajima_d = dval;
      stats.site_count = m[10:0];
      return 1'b1;
   endfunction

   function automatic logic [23:0] harmonic_q20(longint unsigned n, bit squared);
      real acc;
      acc = 0.0;
      for (int i = 1; i < n; i++) begin
         acc = acc + (squared ? 1.0 / (i * i) : 1.0 / i);
      end
      return 24'($rtoi(acc * 1048576.0));
   endfunction

   task automatic write_csr(logic [2:0] idx, logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      apply_csr(idx, value);
   endtask

   // Waits for every outstanding window result, then lets in-flight sites drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_site(logic [15:0] position, logic [63:0] alleles, logic last,
                            bit typed, window_stats_type typed_stats);
      window_stats_type stats;
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
      end
      req_valid <= 1'b1;
      req_site_position <= position;
      req_allele_bits <= alleles;
      req_last_site <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      if (predict_window(position, alleles, last, stats)) begin
         pending_stats.push_back(typed ? typed_stats : stats);
      end
   endtask

   task automatic add_site(logic [15:0] position, logic [63:0] alleles, logic last);
      stim_row_type row;
      row = '{ROW_SITE, 3'd0, 24'd0, position, alleles, last, 1'b0, '0};
      stim_rows.push_back(row);
   endtask

   task automatic add_typed_site(logic [15:0] position, logic [63:0] alleles,
                                 window_stats_type stats);
      stim_row_type row;
      row = '{ROW_SITE, 3'd0, 24'd0, position, alleles, 1'b1, 1'b1, stats};
      stim_rows.push_back(row);
   endtask

   task automatic add_csr(logic [2:0] idx, logic [23:0] value);
      stim_row_type row;
      row = '{ROW_CSR, idx, value, 16'd0, 64'd0, 1'b0, 1'b0, '0};
      stim_rows.push_back(row);
   endtask

   task automatic random_config();
      longint unsigned n_raw;
      longint unsigned lo;
      longint unsigned hi;
      int unsigned pick;
      n_raw = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 64)
            : (($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) : $urandom_range(65, 127));
      write_csr(CSR_SAMPLE_COUNT, {17'($urandom), 7'(n_raw)});
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         lo = $urandom_range(0, 255);
         hi = $urandom_range(65280, 65535);
      end else if (pick < 8) begin
         lo = $urandom_range(0, 65535);
         hi = $urandom_range(0, 65535);
      end else begin
         lo = $urandom_range(0, 60000);
         hi = lo + $urandom_range(1, 5000);
      end
      write_csr(CSR_WINDOW_LOW, {8'($urandom), 16'(lo)});
      write_csr(CSR_WINDOW_HIGH, {8'($urandom), 16'(hi)});
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         write_csr(CSR_HARMONIC_SUM, harmonic_q20(clamped_samples(), 1'b0));
         write_csr(CSR_HARMONIC_SQUARE_SUM, harmonic_q20(clamped_samples(), 1'b1));
      end else begin
         write_csr(CSR_HARMONIC_SUM, 24'($urandom));
         write_csr(CSR_HARMONIC_SQUARE_SUM, 24'($urandom));
      end
   endtask

   function automatic logic [15:0] random_position();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return 16'(cfg_low);
         1: return 16'(cfg_low + 1);
         2: return 16'(cfg_high);
         3: return 16'(cfg_high + 1);
         4, 5: return 16'($urandom);
         default: begin
            if (cfg_low < cfg_high) return 16'($urandom_range(cfg_low + 1, cfg_high));
            return 16'($urandom);
         end
      endcase
   endfunction

   function automatic logic [63:0] random_alleles();
      logic [63:0] a;
      logic [63:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return a & b;
         1: return a | b;
         2: return '0;
         3: return '1;
         default: return a;
      endcase
   endfunction

   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (ready_mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_mode_left = $urandom_range(20, 400);
         end
         ready_mode_left--;
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      window_stats_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_stats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected result transaction at %0t", $realtime);
            end
         end else begin
            want = pending_stats.pop_front();
            if (rsp_diversity_sum !== want.diversity_sum
                || rsp_diversity_spread !== want.diversity_spread
                || rsp_watterson_theta !== want.watterson_theta
                || rsp_tajima_d !== want.tajima_d
                || rsp_site_count !== want.site_count) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch at %0t: expected pi=%h spread=%h theta=%h d=%h n=%0d",
                           $realtime, want.diversity_sum, want.diversity_spread,
                           want.watterson_theta, want.tajima_d, want.site_count);
                  $display("   actual pi=%h spread=%h theta=%h d=%h n=%0d",
                           rsp_diversity_sum, rsp_diversity_spread, rsp_watterson_theta,
                           rsp_tajima_d, rsp_site_count);
               end
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      int unsigned phase_items;
      int unsigned run_len;
      bit paused;
      reset = 1'b1;
      req_valid = 1'b0;
      req_site_position = '0;
      req_allele_bits = '0;
      req_last_site = 1'b0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_SAMPLE_COUNT;
      csr_data = '0;
      mismatch_count = 0;
      burst_left = 0;
      hold_requests = 0;
      hold_served = 0;
      hold_left = 0;
      ready_mode = 0;
      ready_mode_left = 0;
      cfg_samples = 64;
      cfg_low = 0;
      cfg_high = 65535;
      cfg_a1 = 0;
      cfg_a2 = 0;
      sum_sites = 0;
      sum_pairs = 0;
      sum_pair_squares = 0;

      // Reset configuration has a zero harmonic sum, so theta and D saturate.
      add_typed_site(16'd5, 64'd0, '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'sh8000_0000, 11'd1});
      add_typed_site(16'd0, '1, '0);
      add_site(16'hFFFF, '1, 1'b0);
      add_site(16'd1, 64'd1, 1'b0);
      add_site(16'h8000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      add_csr(CSR_SAMPLE_COUNT, 24'hFFFF82);
      add_csr(CSR_HARMONIC_SUM, 24'h100000);
      add_csr(CSR_HARMONIC_SQUARE_SUM, 24'h100000);
      add_site(16'd10, 64'd1, 1'b0);
      add_site(16'd11, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      add_site(16'd12, 64'd0, 1'b1);
      add_csr(CSR_SAMPLE_COUNT, 24'h000000);
      add_site(16'd7, 64'd3, 1'b1);
      add_csr(CSR_SAMPLE_COUNT, 24'h00007F);
      add_csr(CSR_HARMONIC_SUM, 24'hFFFFFF);
      add_csr(CSR_HARMONIC_SQUARE_SUM, 24'hFFFFFF);
      add_site(16'd100, 64'h0000_0000_FFFF_FFFF, 1'b0);
      add_site(16'd200, 64'h5555_5555_5555_5555, 1'b1);
      add_csr(CSR_WINDOW_LOW, 24'h004000);
      add_csr(CSR_WINDOW_HIGH, 24'h004000);
      add_typed_site(16'h4000, '1, '0);
      add_csr(CSR_WINDOW_LOW, 24'hFFFFFF);
      add_csr(CSR_WINDOW_HIGH, 24'h000000);
      add_typed_site(16'hFFFF, '1, '0);
      add_csr(CSR_SPARE_A, 24'hFFFFFF);
      add_csr(CSR_SPARE_B, 24'hFFFFFF);
      add_csr(CSR_SPARE_C, 24'hFFFFFF);
      add_csr(CSR_WINDOW_LOW, 24'h000000);
      add_csr(CSR_WINDOW_HIGH, 24'h00FFFF);
      add_site(16'h1234, 64'h8000_0000_0000_0001, 1'b0);
      add_site(16'hFFFF, 64'h0F0F_0F0F_F0F0_F0F0, 1'b1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            write_csr(row.csr_idx, row.csr_value);
         end else begin
            send_site(row.position, row.alleles, row.last, row.typed, row.stats);
         end
      end

      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         random_config();
         if (phase == 3) hold_requests++;
         phase_items = 0;
         paused = 1'b0;
         while (phase_items < 140) begin
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 20);
            for (int s = 0; s < run_len; s++) begin
               send_site(random_position(), random_alleles(),
                         (s == run_len - 1) || ($urandom_range(0, 29) == 0), 1'b0, '0);
            end
            phase_items += run_len;
            if (phase == 5 && !paused && phase_items > 60) begin
               paused = 1'b1;
               req_valid <= 1'b0;
               burst_left = 0;
               while (pending_stats.size() != 0) @(posedge clock);
            end
         end
      end

      // Fill the site counter past its limit within one window.
      wait_idle();
      write_csr(CSR_SAMPLE_COUNT, 24'd64);
      write_csr(CSR_WINDOW_LOW, 24'd0);
      write_csr(CSR_WINDOW_HIGH, 24'hFFFF);
      write_csr(CSR_HARMONIC_SUM, harmonic_q20(64, 1'b0));
      write_csr(CSR_HARMONIC_SQUARE_SUM, harmonic_q20(64, 1'b1));
      for (int s = 0; s < SITE_CAP_INT + 12; s++) begin
         send_site(16'($urandom_range(1, 65535)), random_alleles(),
                   s == SITE_CAP_INT + 11, 1'b0, '0);
      end

      wait_idle();
      repeat (2000) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
